FILE: rtl/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgc_pkg;

  localparam int COORD_BITS     = 12;
  localparam int SPAN_FRAC_BITS = 4;

  localparam int COUNT_W = 4;
  localparam int STAMP_W = 32;
  localparam int SWIPE_W = 12;
  localparam int FLICK_W = 16;
  localparam int PINCH_W = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWIPE_DISTANCE = 2'd0,
    REG_FLICK_TIME     = 2'd1,
    REG_PINCH_THRESH   = 2'd2
  } cfg_reg_t;

  localparam logic [SWIPE_W-1:0] SWIPE_RESET = SWIPE_W'(80);
  localparam logic [FLICK_W-1:0] FLICK_RESET = FLICK_W'(200);
  localparam logic [PINCH_W-1:0] PINCH_RESET = PINCH_W'(80);

  // input item layout
  localparam int IN_COUNT_LO = 0;
  localparam int IN_X0_LO    = IN_COUNT_LO + COUNT_W;
  localparam int IN_Y0_LO    = IN_X0_LO + COORD_BITS;
  localparam int IN_X1_LO    = IN_Y0_LO + COORD_BITS;
  localparam int IN_Y1_LO    = IN_X1_LO + COORD_BITS;
  localparam int IN_NOW_LO   = IN_Y1_LO + COORD_BITS;
  localparam int IN_W        = IN_NOW_LO + STAMP_W;
  localparam int IN_DATA_W   = ((IN_W + 7) / 8) * 8;

  // result item layout
  localparam int OUT_TOUCHING = 5;
  localparam int OUT_W        = 6 + 4 * COORD_BITS + COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_W + 7) / 8) * 8;

  // arithmetic widths
  localparam int SQ_W    = (COORD_BITS > SWIPE_W) ? COORD_BITS : SWIPE_W;
  localparam int ACC_W   = 2 * SQ_W + 1;
  localparam int DSQ_W   = 2 * COORD_BITS + 1;
  localparam int RAD_W   = DSQ_W + 2 * SPAN_FRAC_BITS;
  localparam int ROOT_W  = (RAD_W + 1) / 2;
  localparam int PAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int STEP_W  = $clog2(ROOT_W);
  localparam int CMP_W   = (ROOT_W > PINCH_W) ? ROOT_W : PINCH_W;

endpackage
`default_nettype wire

FILE: rtl/touch_gesture_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Touch gesture classifier: one result item per touch frame item. A shared squarer
// forms squared travel and squared finger distance; a bit-per-cycle square root
// gives the finger distance with SPAN_FRAC_BITS fraction bits. The input side is
// held off while a frame is worked on. A frame with one touch, or a release with
// no touch held, goes straight to the final step; a release of a held touch first
// makes three squarer passes; a frame with two or more touches makes two squarer
// passes and then the 17-step square root loop. A finished result sits in the
// output register, so the next frame is taken while it waits; the final step waits
// only if that register is still full. Configuration writes take effect at once.
module touch_gesture_classifier (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // touch_count, first_x, first_y, second_x, second_y, now_ms
  input  wire logic [tgc_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // tap, swipe, flick, pinch_in, pinch_out, touching, begin_x, begin_y,
  // now_x, now_y, count_seen
  output logic [tgc_pkg::OUT_DATA_W-1:0]           m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CB = tgc_pkg::COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_ROOT,
    S_FIN
  } state_t;

  state_t state;

  logic [tgc_pkg::SWIPE_W-1:0] swipe_distance;
  logic [tgc_pkg::FLICK_W-1:0] flick_time_ms;
  logic [tgc_pkg::PINCH_W-1:0] pinch_threshold_q4;

  logic                        held;
  logic [CB-1:0]               start_px_x;
  logic [CB-1:0]               start_px_y;
  logic [CB-1:0]               track_px_x;
  logic [CB-1:0]               track_px_y;
  logic [tgc_pkg::STAMP_W-1:0] start_stamp;
  logic [tgc_pkg::ROOT_W-1:0]  last_span;

  logic [tgc_pkg::COUNT_W-1:0] cnt_r;
  logic [CB-1:0]               x0_r;
  logic [CB-1:0]               y0_r;
  logic [CB-1:0]               x1_r;
  logic [CB-1:0]               y1_r;
  logic [tgc_pkg::STAMP_W-1:0] now_r;

  logic [tgc_pkg::ACC_W-1:0]     acc;
  logic [2*tgc_pkg::SWIPE_W-1:0] lim;
  logic [tgc_pkg::PAD_W-1:0]     rad;
  logic [tgc_pkg::REM_W-1:0]     rem;
  logic [tgc_pkg::ROOT_W-1:0]    root;
  logic [tgc_pkg::STEP_W-1:0]    step;

  logic                          release_r;
  logic                          s_accept;
  logic                          out_free;

  logic [tgc_pkg::SQ_W-1:0]      sq_a;
  logic [tgc_pkg::SQ_W-1:0]      sq_b;
  logic [tgc_pkg::SQ_W-1:0]      sq_d;
  logic [2*tgc_pkg::SQ_W-1:0]    sq_p;
  logic [tgc_pkg::ACC_W-1:0]     acc_sum;

  logic [tgc_pkg::REM_W-1:0]     rem_sh;
  logic [tgc_pkg::REM_W-1:0]     trial;
  logic                          rem_ge;

  logic [tgc_pkg::STAMP_W-1:0]   elapsed;
  logic                          f_tap;
  logic                          f_swipe;
  logic                          f_flick;
  logic                          f_pin;
  logic                          f_pout;
  logic                          held_next;
  logic [CB-1:0]                 start_x_next;
  logic [CB-1:0]                 start_y_next;
  logic [CB-1:0]                 track_x_next;
  logic [CB-1:0]                 track_y_next;
  logic [tgc_pkg::CMP_W-1:0]     span_w;
  logic [tgc_pkg::CMP_W-1:0]     last_w;
  logic [tgc_pkg::CMP_W-1:0]     delta;
  logic                          over;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign release_r = (cnt_r == '0);

  // shared squarer
  always_comb begin
    sq_a = '0;
    sq_b = '0;
    unique case (state)
      S_SQ0: begin
        sq_a = release_r ? tgc_pkg::SQ_W'(track_px_x) : tgc_pkg::SQ_W'(x1_r);
        sq_b = release_r ? tgc_pkg::SQ_W'(start_px_x) : tgc_pkg::SQ_W'(x0_r);
      end
      S_SQ1: begin
        sq_a = release_r ? tgc_pkg::SQ_W'(track_px_y) : tgc_pkg::SQ_W'(y1_r);
        sq_b = release_r ? tgc_pkg::SQ_W'(start_px_y) : tgc_pkg::SQ_W'(y0_r);
      end
      S_SQ2: begin
        sq_a = tgc_pkg::SQ_W'(swipe_distance);
      end
      default: begin
      end
    endcase
    sq_d = (sq_a > sq_b) ? (sq_a - sq_b) : (sq_b - sq_a);
    sq_p = (2*tgc_pkg::SQ_W)'(sq_d) * (2*tgc_pkg::SQ_W)'(sq_d);
    acc_sum = acc + tgc_pkg::ACC_W'(sq_p);
  end

  // one root digit per cycle
  always_comb begin
    rem_sh = {rem[tgc_pkg::REM_W-3:0], rad[tgc_pkg::PAD_W-1 -: 2]};
    trial  = tgc_pkg::REM_W'({root, 2'b01});
    rem_ge = (rem_sh >= trial);
  end

  // final decision
  always_comb begin
    elapsed      = now_r - start_stamp;
    f_tap        = 1'b0;
    f_swipe      = 1'b0;
    f_flick      = 1'b0;
    f_pin        = 1'b0;
    f_pout       = 1'b0;
    held_next    = held;
    start_x_next = start_px_x;
    start_y_next = start_px_y;
    track_x_next = track_px_x;
    track_y_next = track_px_y;
    span_w       = tgc_pkg::CMP_W'(root);
    last_w       = tgc_pkg::CMP_W'(last_span);
    delta        = (span_w > last_w) ? (span_w - last_w) : (last_w - span_w);
    over         = (delta > tgc_pkg::CMP_W'(pinch_threshold_q4));
    if (release_r) begin
      if (held) begin
        if (acc < tgc_pkg::ACC_W'(lim)) begin
          f_tap = 1'b1;
        end else begin
          f_swipe = 1'b1;
          f_flick = (elapsed <= tgc_pkg::STAMP_W'(flick_time_ms));
        end
      end
      held_next = 1'b0;
    end else begin
      if (!held) begin
        start_x_next = x0_r;
        start_y_next = y0_r;
      end
      held_next    = 1'b1;
      track_x_next = x0_r;
      track_y_next = y0_r;
      if (cnt_r >= tgc_pkg::COUNT_W'(2) && last_span != '0 && over) begin
        f_pout = (span_w > last_w);
        f_pin  = !(span_w > last_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      m_tvalid           <= 1'b0;
      swipe_distance     <= tgc_pkg::SWIPE_RESET;
      flick_time_ms      <= tgc_pkg::FLICK_RESET;
      pinch_threshold_q4 <= tgc_pkg::PINCH_RESET;
      held               <= 1'b0;
      start_px_x         <= '0;
      start_px_y         <= '0;
      track_px_x         <= '0;
      track_px_y         <= '0;
      start_stamp        <= '0;
      last_span          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tgc_pkg::REG_SWIPE_DISTANCE:
            swipe_distance <= cfg_data[tgc_pkg::SWIPE_W-1:0];
          tgc_pkg::REG_FLICK_TIME:
            flick_time_ms <= cfg_data[tgc_pkg::FLICK_W-1:0];
          tgc_pkg::REG_PINCH_THRESH:
            pinch_threshold_q4 <= cfg_data[tgc_pkg::PINCH_W-1:0];
          default: begin
          end
        endcase
      end

      // the final step reloads the output register itself
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            cnt_r <= s_tdata[tgc_pkg::IN_COUNT_LO +: tgc_pkg::COUNT_W];
            x0_r  <= s_tdata[tgc_pkg::IN_X0_LO +: CB];
            y0_r  <= s_tdata[tgc_pkg::IN_Y0_LO +: CB];
            x1_r  <= s_tdata[tgc_pkg::IN_X1_LO +: CB];
            y1_r  <= s_tdata[tgc_pkg::IN_Y1_LO +: CB];
            now_r <= s_tdata[tgc_pkg::IN_NOW_LO +: tgc_pkg::STAMP_W];
            acc   <= '0;
            if (s_tdata[tgc_pkg::IN_COUNT_LO +: tgc_pkg::COUNT_W] == '0) begin
              state <= held ? S_SQ0 : S_FIN;
            end else if (s_tdata[tgc_pkg::IN_COUNT_LO +: tgc_pkg::COUNT_W] >=
                         tgc_pkg::COUNT_W'(2)) begin
              state <= S_SQ0;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SQ0: begin
          acc   <= acc_sum;
          state <= S_SQ1;
        end
        S_SQ1: begin
          acc <= acc_sum;
          if (release_r) begin
            state <= S_SQ2;
          end else begin
            rad   <= tgc_pkg::PAD_W'(acc_sum[tgc_pkg::DSQ_W-1:0]) <<
                     (2 * tgc_pkg::SPAN_FRAC_BITS);
            rem   <= '0;
            root  <= '0;
            step  <= tgc_pkg::STEP_W'(tgc_pkg::ROOT_W - 1);
            state <= S_ROOT;
          end
        end
        S_SQ2: begin
          lim   <= sq_p[2*tgc_pkg::SWIPE_W-1:0];
          state <= S_FIN;
        end
        S_ROOT: begin
          rad  <= rad << 2;
          rem  <= rem_ge ? (rem_sh - trial) : rem_sh;
          root <= {root[tgc_pkg::ROOT_W-2:0], rem_ge};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            held       <= held_next;
            start_px_x <= start_x_next;
            start_px_y <= start_y_next;
            track_px_x <= track_x_next;
            track_px_y <= track_y_next;
            if (!release_r && !held) begin
              start_stamp <= now_r;
            end
            if (release_r) begin
              last_span <= '0;
            end else if (cnt_r >= tgc_pkg::COUNT_W'(2)) begin
              last_span <= root;
            end
            m_tdata  <= tgc_pkg::OUT_DATA_W'({cnt_r, track_y_next, track_x_next,
                                              start_y_next, start_x_next, held_next,
                                              f_pout, f_pin, f_flick, f_swipe, f_tap});
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("input taken while a frame is in progress");

  a_touching_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (m_tdata[tgc_pkg::OUT_TOUCHING] == held))
    else $error("touching flag differs from held state");

  a_tap_xor_swipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("tap and swipe in one result");

  a_flick_is_swipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("flick without swipe");

  a_pinch_one_way: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
    else $error("pinch in and out in one result");

endmodule
`default_nettype wire

FILE: verif/tb_touch_gesture_classifier.sv
`timescale 1ns / 1ps
module tb_touch_gesture_classifier;
  import tgc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_COORD   = (1 << COORD_BITS) - 1;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [COUNT_W-1:0]    touches;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [STAMP_W-1:0]    stamp;
  } frame_t;

  typedef struct packed {
    logic [COUNT_W-1:0]    count_seen;
    logic [COORD_BITS-1:0] now_y, now_x, begin_y, begin_x;
    logic                  touching, pinch_out, pinch_in, flick, swipe, tap;
  } gesture_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  // touch_count, first_x, first_y, second_x, second_y, now_ms
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  // tap, swipe, flick, pinch_in, pinch_out, touching, begin_x, begin_y,
  // now_x, now_y, count_seen
  wire  [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SWIPE_DISTANCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touch_gesture_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // gesture tracker state and its register copies
  logic [SWIPE_W-1:0]    swipe_px = SWIPE_RESET;
  logic [FLICK_W-1:0]    flick_ms = FLICK_RESET;
  logic [PINCH_W-1:0]    pinch_q4 = PINCH_RESET;
  bit                    touch_held = 1'b0;
  logic [COORD_BITS-1:0] begin_px_x = '0, begin_px_y = '0, track_x = '0, track_y = '0;
  logic [STAMP_W-1:0]    begin_stamp = '0;
  longint unsigned       prev_span = 0;

  frame_t   frames_to_send[$];
  gesture_t results_due[$];
  frame_t   frame_on_bus;
  gesture_t predicted, seen, want;

  logic [STAMP_W-1:0] clock_ms;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  cycles = 0;
  int  frames_taken = 0;
  int  results_checked = 0;
  int  mismatches = 0;
  int  settings_tried = 1;
  int  taps = 0, swipes = 0, flicks = 0, pinch_ins = 0, pinch_outs = 0;

  function automatic logic [COORD_BITS-1:0] clip(input int v);
    if (v < 0) return '0;
    if (v > MAX_COORD) return COORD_BITS'(MAX_COORD);
    return COORD_BITS'(v);
  endfunction

  function automatic longint unsigned sq_gap(input logic [COORD_BITS-1:0] a, b);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic longint unsigned span_root(input longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = longint'(1) << ROOT_W;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic gesture_t classify_frame(input frame_t f);
    gesture_t        r;
    longint unsigned travel, limit, span;
    logic [STAMP_W-1:0] elapsed;
    r = '0;
    if (f.touches == 0) begin
      if (touch_held) begin
        travel  = sq_gap(track_x, begin_px_x) + sq_gap(track_y, begin_px_y);
        limit   = swipe_px;
        limit   = limit * limit;
        elapsed = f.stamp - begin_stamp;
        if (travel < limit) begin
          r.tap = 1'b1;
        end else begin
          r.swipe = 1'b1;
          r.flick = (elapsed <= STAMP_W'(flick_ms));
        end
      end
      touch_held = 1'b0;
      prev_span  = 0;
    end else begin
      if (!touch_held) begin
        touch_held  = 1'b1;
        begin_px_x  = f.x0;
        begin_px_y  = f.y0;
        begin_stamp = f.stamp;
      end
      track_x = f.x0;
      track_y = f.y0;
      if (f.touches >= 2) begin
        span = span_root((sq_gap(f.x1, f.x0) + sq_gap(f.y1, f.y0)) << (2 * SPAN_FRAC_BITS));
        if (prev_span != 0) begin
          if (span > prev_span) r.pinch_out = (span - prev_span > longint'(pinch_q4));
          else r.pinch_in = (prev_span - span > longint'(pinch_q4));
        end
        prev_span = span;
      end
    end
    r.touching   = touch_held;
    r.begin_x    = begin_px_x;
    r.begin_y    = begin_px_y;
    r.now_x      = track_x;
    r.now_y      = track_y;
    r.count_seen = f.touches;
    return r;
  endfunction

  function automatic string show(input gesture_t g);
    return $sformatf("tap=%0b swipe=%0b flick=%0b in=%0b out=%0b held=%0b begin=(%0d,%0d) now=(%0d,%0d) n=%0d",
                     g.tap, g.swipe, g.flick, g.pinch_in, g.pinch_out, g.touching,
                     g.begin_x, g.begin_y, g.now_x, g.now_y, g.count_seen);
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic queue_frame(input int touches, input int x0, input int y0,
                             input int x1, input int y1, input logic [STAMP_W-1:0] stamp);
    frame_t f;
    f.touches = COUNT_W'(touches);
    f.x0      = clip(x0);
    f.y0      = clip(y0);
    f.x1      = clip(x1);
    f.y1      = clip(y1);
    f.stamp   = stamp;
    frames_to_send.push_back(f);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SWIPE_DISTANCE: swipe_px = val[SWIPE_W-1:0];
      REG_FLICK_TIME:     flick_ms = val[FLICK_W-1:0];
      REG_PINCH_THRESH:   pinch_q4 = val[PINCH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_gestures(input int target);
    int added, kind, sx, sy, x, y, d, e, r, cnt;
    logic [STAMP_W-1:0] t0, dur;
    added = 0;
    @(negedge clk);
    while (added < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 0 || kind == 9) begin
        // noise: random counts and fields
        repeat ($urandom_range(1, 3)) begin
          queue_frame(kind == 9 ? 0 : $urandom_range(0, 15),
                      $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                      $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD), $urandom);
          added++;
        end
      end else if (kind <= 4) begin
        // one finger stroke around the swipe distance
        sx = $urandom_range(0, MAX_COORD);
        sy = $urandom_range(0, MAX_COORD);
        r  = int'(swipe_px) + 2;
        t0 = clock_ms;
        queue_frame(1, sx, sy, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                    clock_ms);
        added++;
        repeat ($urandom_range(0, 4)) begin
          clock_ms = clock_ms + $urandom_range(0, 50);
          if ($urandom_range(0, 3) == 0) begin
            x = $urandom_range(0, MAX_COORD);
            y = $urandom_range(0, MAX_COORD);
          end else begin
            x = sx + int'($urandom_range(0, 2 * r)) - r;
            y = sy + int'($urandom_range(0, 2 * r)) - r;
          end
          cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 1;
          queue_frame(cnt, x, y, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                      clock_ms);
          added++;
        end
        case ($urandom_range(0, 3))
          0:       dur = STAMP_W'(flick_ms);
          1:       dur = STAMP_W'(flick_ms) + 1;
          2:       dur = $urandom_range(0, 2 * int'(flick_ms) + 4);
          default: dur = $urandom;
        endcase
        if ($urandom_range(0, 7) != 0) begin
          clock_ms = t0 + dur;
          repeat ($urandom_range(0, 7) == 0 ? 2 : 1) begin
            queue_frame(0, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                        $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD), clock_ms);
            added++;
          end
        end
      end else begin
        // mostly two or more fingers, distance walking around the pinch threshold
        x = $urandom_range(0, MAX_COORD);
        y = $urandom_range(0, MAX_COORD);
        d = $urandom_range(0, 1500);
        e = int'(pinch_q4) / (1 << SPAN_FRAC_BITS) + 2;
        repeat ($urandom_range(2, 6)) begin
          d = d + int'($urandom_range(0, 2 * e)) - e;
          if (d < 0) d = 0;
          cnt = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 15);
          queue_frame(cnt, x, y, (x > MAX_COORD / 2) ? x - d : x + d,
                      y + int'($urandom_range(0, 6)) - 3, clock_ms);
          added++;
          clock_ms = clock_ms + $urandom_range(1, 30);
        end
        if ($urandom_range(0, 4) != 0) begin
          queue_frame(0, 0, 0, 0, 0, clock_ms);
          added++;
        end
      end
      clock_ms = clock_ms + $urandom_range(1, 500);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted = classify_frame(frame_on_bus);
        results_due.push_back(predicted);
        frames_taken++;
        taps       += predicted.tap;
        swipes     += predicted.swipe;
        flicks     += predicted.flick;
        pinch_ins  += predicted.pinch_in;
        pinch_outs += predicted.pinch_out;
      end
      if (!s_tvalid || s_tready) begin
        if (frames_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= 30)) begin
          frame_on_bus = frames_to_send.pop_front();
          s_tdata  <= IN_DATA_W'({frame_on_bus.stamp, frame_on_bus.y1, frame_on_bus.x1,
                                  frame_on_bus.y0, frame_on_bus.x0, frame_on_bus.touches});
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = m_tdata[OUT_W-1:0];
        if (results_due.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", show(seen)));
        end else begin
          want = results_due.pop_front();
          if (seen.tap !== want.tap || seen.swipe !== want.swipe ||
              seen.flick !== want.flick || seen.pinch_in !== want.pinch_in ||
              seen.pinch_out !== want.pinch_out || seen.touching !== want.touching ||
              seen.begin_x !== want.begin_x || seen.begin_y !== want.begin_y ||
              seen.now_x !== want.now_x || seen.now_y !== want.now_y ||
              seen.count_seen !== want.count_seen)
            note_failure($sformatf("result %0d mismatch\n  expected %s\n  actual   %s",
                                   results_checked, show(want), show(seen)));
          results_checked++;
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || $urandom_range(0, 99) >= 30;
      end
    end
  end

  initial begin
    int phase;
    clock_ms = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: release edges, tap and swipe boundaries, pinch cases
    queue_frame(0, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 32'hFFFF_FFFF);
    queue_frame(1, 0, 0, MAX_COORD, MAX_COORD, 32'hFFFF_FFF0);
    queue_frame(1, MAX_COORD, MAX_COORD, 0, 0, 32'hFFFF_FFF8);
    queue_frame(0, 0, 0, 0, 0, 32'h0000_00B8);
    queue_frame(1, 100, 100, 0, 0, 1000);
    queue_frame(1, 179, 100, 0, 0, 1100);
    queue_frame(0, 0, 0, 0, 0, 1150);
    queue_frame(1, 200, 200, 0, 0, 2000);
    queue_frame(1, 200, 280, 0, 0, 2100);
    queue_frame(0, 0, 0, 0, 0, 2201);
    queue_frame(2, 1000, 1000, 1100, 1000, 3000);
    queue_frame(2, 1000, 1000, 1106, 1000, 3010);
    queue_frame(2, 1000, 1000, 1101, 1000, 3020);
    queue_frame(3, 1000, 1000, 1096, 1000, 3030);
    queue_frame(2, 1000, 1000, 1090, 1000, 3040);
    queue_frame(1, 1000, 1000, 0, 0, 3050);
    queue_frame(4, 1000, 1000, 1200, 1000, 3060);
    queue_frame(2, 1000, 1000, 1000, 1000, 3070);
    queue_frame(15, 0, 0, MAX_COORD, MAX_COORD, 3080);
    queue_frame(2, MAX_COORD, MAX_COORD, 0, 0, 3090);
    queue_frame(2, MAX_COORD, 0, 0, MAX_COORD, 3100);
    queue_frame(0, 3, 5, 7, 9, 3200);
    queue_frame(0, 3, 5, 7, 9, 3250);
    queue_frame(2, 10, 10, 13, 14, 3300);
    queue_frame(0, 0, 0, 0, 0, 3400);
    wait_idle();

    write_reg(REG_SWIPE_DISTANCE, '0);
    write_reg(REG_FLICK_TIME, '0);
    write_reg(REG_PINCH_THRESH, '0);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    settings_tried++;
    add_gestures(60);
    wait_idle();

    write_reg(REG_SWIPE_DISTANCE, '1);
    write_reg(REG_FLICK_TIME, '1);
    write_reg(REG_PINCH_THRESH, '1);
    settings_tried++;
    add_gestures(60);
    wait_idle();

    for (phase = 0; phase < 3; phase++) begin
      write_reg(REG_SWIPE_DISTANCE, CFG_DATA_W'($urandom_range(1, 300)));
      write_reg(REG_FLICK_TIME, CFG_DATA_W'($urandom_range(0, 1000)));
      write_reg(REG_PINCH_THRESH, CFG_DATA_W'($urandom_range(0, 400)));
      settings_tried++;
      @(negedge clk);
      steady = (phase == 1);
      // long receiver hold-off while frames keep coming
      if (phase == 2) hold_req = 1'b1;
      add_gestures(90);
      wait_idle();
    end

    repeat (30) @(posedge clk);
    $display("checked %0d results from %0d frames over %0d register settings, %0d mismatches",
             results_checked, frames_taken, settings_tried, mismatches);
    $display("gestures seen: %0d taps, %0d swipes, %0d flicks, %0d pinch-in, %0d pinch-out",
             taps, swipes, flicks, pinch_ins, pinch_outs);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
